>>> rtl/crtm_pkg.sv
`timescale 1ns / 1ps
// Package for the congruence merger: widths and sequencer states.
// Used by crtm_divider and crt_congruence_merger_unit; depends on nothing.
package crtm_pkg;

	localparam int VALUE_BITS_DEF = 63;
	localparam int DATA_BYTES_DEF = (2 * VALUE_BITS_DEF + 7) / 8;

	typedef enum logic [13:0] {
		ST_IDLE    = 14'b00000000000001,
		ST_RM      = 14'b00000000000010,
		ST_CUR     = 14'b00000000000100,
		ST_GCD     = 14'b00000000001000,
		ST_DIFFG   = 14'b00000000010000,
		ST_MP      = 14'b00000000100000,
		ST_OVF     = 14'b00000001000000,
		ST_BG      = 14'b00000010000000,
		ST_EUC     = 14'b00000100000000,
		ST_MULQ    = 14'b00001000000000,
		ST_KRED    = 14'b00010000000000,
		ST_MULK    = 14'b00100000000000,
		ST_UPD     = 14'b01000000000000,
		ST_OUT     = 14'b10000000000000
	} state_t;

endpackage

>>> rtl/crtm_divider.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle: quotient and remainder of num / den.
// Depends on crtm_pkg.
module crtm_divider #(
	parameter int VALUE_BITS = crtm_pkg::VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [VALUE_BITS-1:0] num,
	input  logic [VALUE_BITS-1:0] den,
	output logic                  done,
	output logic [VALUE_BITS-1:0] quo,
	output logic [VALUE_BITS-1:0] rem
);
	localparam int CW = $clog2(VALUE_BITS + 1);

	logic [CW-1:0]         cnt_q;
	logic                  busy_q;
	logic [VALUE_BITS-1:0] quo_q;
	logic [VALUE_BITS:0]   rem_q;
	logic [VALUE_BITS-1:0] den_q;
	logic [VALUE_BITS:0]   trial;

	assign trial = {rem_q[VALUE_BITS-1:0], quo_q[VALUE_BITS-1]};

	// shift one numerator bit in per cycle, subtract when it fits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(VALUE_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			if (trial >= {1'b0, den_q}) begin
				rem_q <= trial - {1'b0, den_q};
				quo_q <= {quo_q[VALUE_BITS-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[VALUE_BITS-2:0], 1'b0};
			end
		end
	end

	assign quo = quo_q;
	assign rem = rem_q[VALUE_BITS-1:0];
endmodule

>>> rtl/crt_congruence_merger_unit.sv
`timescale 1ns / 1ps
// Top level of the congruence merger: sequencer, shift-add multiplier, result register.
// Depends on crtm_pkg and crtm_divider.
// Each congruence transaction is worked on by one shared bit-serial divider and one
// shift-add multiplier. A divider pass is a start, one step per quotient bit, then
// done; a modular or plain product takes one shift-add step per multiplier bit. When
// the new modulus adds a factor, a transaction also runs a gcd loop of divider passes
// and an extended Euclid loop of a divider pass and a modular product per step.
// Error and already-frozen transactions finish much sooner.
// s_tready is low while a transaction is worked on; the result waits in an output
// register and the next input is taken once it is delivered.
module crt_congruence_merger_unit #(
	parameter int VALUE_BITS = crtm_pkg::VALUE_BITS_DEF,
	parameter int DATA_BYTES = (2 * VALUE_BITS + 7) / 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	// modulus, residue
	input  logic [DATA_BYTES*8-1:0] s_tdata,
	input  logic                    s_tlast,
	output logic                    m_tvalid,
	input  logic                    m_tready,
	// combined_residue, combined_modulus
	output logic [DATA_BYTES*8-1:0] m_tdata,
	// no_solution, overflow
	output logic [1:0]              m_tuser,
	output logic                    m_tlast
);
	localparam int W  = VALUE_BITS;
	localparam int CW = $clog2(W + 2);

	crtm_pkg::state_t st_q;

	logic [W-1:0] rr_q, bm_q, m_q, rm_q, cur_q, g_q, diff_q, mp_q, bg_q;
	logic [W-1:0] r0_q, r1_q, s0_q, s1_q, k_q;
	logic [1:0]   err_q;
	logic         last_q;
	logic         phase_q;
	logic [W-1:0] ga_q, gb_q;

	// multiplier state: acc = a*b mod mm, or plain product when mm is zero
	logic [W-1:0] ma_q, mb_q, mm_q, macc_q;
	logic [CW-1:0] mcnt_q;
	logic [W:0]   sum_a, dbl_a;

	logic         dv_start;
	logic [W-1:0] dv_num, dv_den, dv_quo, dv_rem;
	logic         dv_done;

	crtm_divider #(.VALUE_BITS(W)) u_div (
		.clk(clk), .arst_n(arst_n), .start(dv_start), .num(dv_num), .den(dv_den),
		.done(dv_done), .quo(dv_quo), .rem(dv_rem)
	);

	assign sum_a = {1'b0, macc_q} + {1'b0, ma_q};
	assign dbl_a = {ma_q, 1'b0};

	assign s_tready = (st_q == crtm_pkg::ST_IDLE) && !m_tvalid;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= crtm_pkg::ST_IDLE;
			m_tvalid <= 1'b0;
			err_q    <= 2'b00;
			rr_q     <= '0;
			bm_q     <= {{(W-1){1'b0}}, 1'b1};
			dv_start <= 1'b0;
			phase_q  <= 1'b0;
			mcnt_q   <= '0;
		end else begin
			dv_start <= 1'b0;
			if (m_tvalid && m_tready) m_tvalid <= 1'b0;
			unique case (st_q)
				crtm_pkg::ST_IDLE: begin
					if (s_tvalid && s_tready) begin
						m_q    <= s_tdata[W-1:0];
						last_q <= s_tlast;
						if (err_q != 2'b00) st_q <= crtm_pkg::ST_OUT;
						else if (s_tdata[W-1:0] == '0) begin
							err_q[0] <= 1'b1;
							st_q     <= crtm_pkg::ST_OUT;
						end else begin
							dv_num   <= s_tdata[2*W-1:W];
							dv_den   <= s_tdata[W-1:0];
							dv_start <= 1'b1;
							st_q     <= crtm_pkg::ST_RM;
						end
					end
				end
				crtm_pkg::ST_RM: if (dv_done) begin
					rm_q     <= dv_rem;
					dv_num   <= rr_q;
					dv_den   <= m_q;
					dv_start <= 1'b1;
					st_q     <= crtm_pkg::ST_CUR;
				end
				crtm_pkg::ST_CUR: if (dv_done) begin
					cur_q <= dv_rem;
					ga_q  <= bm_q;
					gb_q  <= m_q;
					phase_q <= 1'b0;
					st_q  <= crtm_pkg::ST_GCD;
				end
				crtm_pkg::ST_GCD: begin
					if (!phase_q) begin
						if (gb_q == '0) begin
							g_q      <= ga_q;
							diff_q   <= (rm_q >= cur_q) ? rm_q - cur_q : rm_q + (m_q - cur_q);
							dv_num   <= (rm_q >= cur_q) ? rm_q - cur_q : rm_q + (m_q - cur_q);
							dv_den   <= ga_q;
							dv_start <= 1'b1;
							st_q     <= crtm_pkg::ST_DIFFG;
						end else begin
							dv_num   <= ga_q;
							dv_den   <= gb_q;
							dv_start <= 1'b1;
							phase_q  <= 1'b1;
						end
					end else if (dv_done) begin
						ga_q    <= gb_q;
						gb_q    <= dv_rem;
						phase_q <= 1'b0;
					end
				end
				crtm_pkg::ST_DIFFG: if (dv_done) begin
					if (dv_rem != '0) begin
						err_q[0] <= 1'b1;
						st_q     <= crtm_pkg::ST_OUT;
					end else begin
						diff_q   <= dv_quo;
						dv_num   <= m_q;
						dv_den   <= g_q;
						dv_start <= 1'b1;
						st_q     <= crtm_pkg::ST_MP;
					end
				end
				crtm_pkg::ST_MP: if (dv_done) begin
					mp_q     <= dv_quo;
					dv_num   <= {W{1'b1}};
					dv_den   <= bm_q;
					dv_start <= 1'b1;
					st_q     <= crtm_pkg::ST_OVF;
				end
				crtm_pkg::ST_OVF: if (dv_done) begin
					if (mp_q > dv_quo) begin
						err_q[1] <= 1'b1;
						st_q     <= crtm_pkg::ST_OUT;
					end else if (mp_q == {{(W-1){1'b0}}, 1'b1}) begin
						k_q  <= '0;
						st_q <= crtm_pkg::ST_MULK;
						ma_q <= bm_q; mb_q <= mp_q; mm_q <= '0; macc_q <= '0;
						mcnt_q <= CW'(W);
						phase_q <= 1'b0;
					end else begin
						dv_num   <= bm_q;
						dv_den   <= g_q;
						dv_start <= 1'b1;
						phase_q  <= 1'b0;
						st_q     <= crtm_pkg::ST_BG;
					end
				end
				crtm_pkg::ST_BG: begin
					// bm/g then reduce mod mp
					if (dv_done && !phase_q) begin
						dv_num   <= dv_quo;
						dv_den   <= mp_q;
						dv_start <= 1'b1;
						phase_q  <= 1'b1;
					end else if (dv_done) begin
						r0_q <= dv_rem; r1_q <= mp_q;
						s0_q <= {{(W-1){1'b0}}, 1'b1}; s1_q <= '0;
						phase_q <= 1'b0;
						st_q <= crtm_pkg::ST_EUC;
					end
				end
				crtm_pkg::ST_EUC: begin
					if (!phase_q) begin
						if (r1_q == '0) begin
							// s0 < mp already; k = (diff/g mod mp) * inv mod mp
							dv_num   <= diff_q;
							dv_den   <= mp_q;
							dv_start <= 1'b1;
							st_q     <= crtm_pkg::ST_KRED;
						end else begin
							dv_num   <= r0_q;
							dv_den   <= r1_q;
							dv_start <= 1'b1;
							phase_q  <= 1'b1;
						end
					end else if (dv_done) begin
						r0_q <= r1_q;
						r1_q <= dv_rem;
						ma_q <= (dv_quo >= mp_q) ? '0 : dv_quo;
						mb_q <= s1_q; mm_q <= mp_q; macc_q <= '0;
						mcnt_q <= CW'(W);
						phase_q <= 1'b0;
						st_q <= crtm_pkg::ST_MULQ;
					end
				end
				crtm_pkg::ST_MULQ: begin
					// q never exceeds mp; it equals mp only when r1 is one, and then q mod mp is zero
					if (mcnt_q == '0) begin
						s0_q <= s1_q;
						s1_q <= (s0_q >= macc_q) ? s0_q - macc_q : s0_q + (mp_q - macc_q);
						st_q <= crtm_pkg::ST_EUC;
					end
				end
				crtm_pkg::ST_KRED: if (dv_done) begin
					ma_q <= dv_rem; mb_q <= s0_q; mm_q <= mp_q; macc_q <= '0;
					mcnt_q <= CW'(W);
					phase_q <= 1'b1;
					st_q <= crtm_pkg::ST_MULK;
				end
				crtm_pkg::ST_MULK: begin
					// phase 1: k = product mod mp; phase 0: new modulus bm*mp
					if (mcnt_q == '0) begin
						if (phase_q) begin
							k_q  <= macc_q;
							ma_q <= bm_q; mb_q <= mp_q; mm_q <= '0; macc_q <= '0;
							mcnt_q <= CW'(W);
							phase_q <= 1'b0;
						end else begin
							bg_q <= macc_q;
							ma_q <= bm_q; mb_q <= k_q; mm_q <= '0; macc_q <= '0;
							mcnt_q <= CW'(W);
							st_q <= crtm_pkg::ST_UPD;
						end
					end
				end
				crtm_pkg::ST_UPD: if (mcnt_q == '0) begin
					rr_q <= rr_q + macc_q;
					bm_q <= bg_q;
					st_q <= crtm_pkg::ST_OUT;
				end
				crtm_pkg::ST_OUT: begin
					m_tvalid <= 1'b1;
					m_tuser  <= err_q;
					m_tlast  <= last_q;
					m_tdata  <= (err_q == 2'b00) ? (DATA_BYTES*8)'({bm_q, rr_q}) : '0;
					if (last_q) begin
						rr_q  <= '0;
						bm_q  <= {{(W-1){1'b0}}, 1'b1};
						err_q <= 2'b00;
					end
					st_q <= crtm_pkg::ST_IDLE;
				end
				default: st_q <= crtm_pkg::ST_IDLE;
			endcase

			// shift-add multiplier step, shared by all product states
			if (mcnt_q != '0) begin
				mcnt_q <= mcnt_q - 1'b1;
				mb_q   <= mb_q >> 1;
				if (mm_q == '0) begin
					if (mb_q[0]) macc_q <= sum_a[W-1:0];
					ma_q <= dbl_a[W-1:0];
				end else begin
					if (mb_q[0])
						macc_q <= (sum_a >= {1'b0, mm_q}) ? W'(sum_a - {1'b0, mm_q})
						                                  : sum_a[W-1:0];
					ma_q <= (dbl_a >= {1'b0, mm_q}) ? W'(dbl_a - {1'b0, mm_q})
					                                : dbl_a[W-1:0];
				end
			end
		end
	end
endmodule

>>> rtl/crtm_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the congruence merger; bound to the top level below.
// Depends on crt_congruence_merger_unit.
module crtm_checker #(
	parameter int DATA_BYTES = 16
) (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    s_tvalid,
	input logic                    s_tready,
	input logic                    m_tvalid,
	input logic                    m_tready,
	input logic [DATA_BYTES*8-1:0] m_tdata,
	input logic [1:0]              m_tuser
);
	// one transaction in flight: no input taken while a result waits
	a_no_accept_pending: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready) else $error("input taken with result pending");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// an error result carries zero data
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != 2'b00) |-> m_tdata == '0)
		else $error("error result with nonzero data");

	// accept is followed by a busy cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready) else $error("ready right after accept");
endmodule

bind crt_congruence_merger_unit crtm_checker #(.DATA_BYTES(DATA_BYTES)) u_chk (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);
